FILE: rtl/cbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_pkg: shared definitions for the comment blanking filter
// Register indexes, character codes, mode codes, the result beat type and
// the configuration bundle used by the filter and its output queue.
// ----------------------------------------------------------------------------
package cbf_pkg;

  // Default sizes for the top-level parameters.
  localparam int MARKER_MAX_DEF = 4;
  localparam int DEPTH_BITS_DEF = 8;

  // Output queue: address bits and the most results one byte can release.
  localparam int Q_ADDR_BITS = 3;
  localparam int Q_WR_MAX    = 4;

  // Marker length fields and configuration index width.
  localparam int LEN_W     = 3;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_MARKER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_MARKER_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MARKER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MARKER_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_MARKER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_MARKER_LEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_QUOTES     = 3'd6;

  // Quote tracking modes.
  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  // Pending trail byte of a two-byte character.
  localparam logic [1:0] PAIR_NONE  = 2'd0;
  localparam logic [1:0] PAIR_PASS  = 2'd1;
  localparam logic [1:0] PAIR_BLANK = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       line_end;
  } cbf_result_t;

  // Configuration register bundle.
  typedef struct packed {
    logic [31:0]      line_marker;
    logic [LEN_W-1:0] line_len;
    logic [31:0]      open_marker;
    logic [LEN_W-1:0] open_len;
    logic [31:0]      close_marker;
    logic [LEN_W-1:0] close_len;
    logic             track_quotes;
  } cbf_cfg_t;

  // Shift-JIS lead byte ranges.
  function automatic logic is_lead(logic [7:0] b);
    return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
  endfunction

  // Comment body bytes turn into spaces, but tabs stay.
  function automatic logic [7:0] body_blank(logic [7:0] b);
    return (b == CH_TAB) ? CH_TAB : CH_SPACE;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cbf_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_out_queue: multi-write result queue
// Takes up to WR_MAX result beats in one cycle and hands them out one beat
// per cycle on a valid/ready port. space_ok says a full burst still fits.
// ----------------------------------------------------------------------------
module cbf_out_queue
  import cbf_pkg::*;
#(
  parameter int WR_MAX    = Q_WR_MAX,
  parameter int ADDR_BITS = Q_ADDR_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(WR_MAX+1)-1:0]    wr_cnt,
  input  cbf_result_t [WR_MAX-1:0]       wr_data,
  output logic                           space_ok,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cbf_result_t                    out_data
);

  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int CW    = $clog2(WR_MAX + 1);
  localparam int NW    = ADDR_BITS + 1;

  cbf_result_t          mem_r [DEPTH];
  logic [ADDR_BITS-1:0] wr_ptr_r;
  logic [ADDR_BITS-1:0] rd_ptr_r;
  logic [NW-1:0]        count_r;
  logic [NW-1:0]        count_nxt;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = (count_r <= NW'(DEPTH - WR_MAX));
  assign count_nxt = count_r + NW'(wr_cnt) - NW'(pop);

  // Storage: the burst lands at consecutive slots after the write pointer.
  always_ff @(posedge clk) begin
    for (int k = 0; k < WR_MAX; k++) begin
      if (CW'(k) < wr_cnt) begin
        mem_r[wr_ptr_r + ADDR_BITS'(k)] <= wr_data[k];
      end
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ADDR_BITS'(wr_cnt);
      rd_ptr_r <= rd_ptr_r + ADDR_BITS'(pop);
      count_r  <= count_nxt;
    end
  end

  // A burst must never overrun the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_cnt != '0) |-> (int'(count_r) + int'(wr_cnt) <= DEPTH))
    else $error("result queue overflow");

  // The pointers stay consistent with the fill level.
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ADDR_BITS'(wr_ptr_r - rd_ptr_r) == count_r[ADDR_BITS-1:0]))
    else $error("result queue pointers disagree with count");

  // A lone read drops the fill level by exactly one.
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    ((wr_cnt == '0) && pop) |=> (count_r == $past(count_r) - NW'(1)))
    else $error("result queue count did not drop on read");

endmodule
`default_nettype wire

FILE: rtl/comment_blanking_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// comment_blanking_filter_unit: streaming source comment stripper
// Source bytes in, the same bytes out with comments turned into spaces.
// Nested block comments, line comments, quoted strings and two-byte
// characters are tracked over a lookahead window of up to four bytes.
// ----------------------------------------------------------------------------
// Path: a byte that can be decided at once goes through the input register
//   and the result queue to out_*; other bytes wait in the window until it
//   holds as many bytes as the longest enabled marker, or the line end beat.
// Throughput: one input beat per cycle while the result queue has room for
//   a full burst of window-size results; results leave one beat per cycle
//   while out_ready is high. Reset: synchronous, active low; clears all
//   control state and resets the configuration registers (close length 1).
module comment_blanking_filter_unit
  import cbf_pkg::*;
#(
  parameter int MARKER_MAX = MARKER_MAX_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_line_end,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_line_end
);

  localparam int WIN_CAP = (MARKER_MAX < 4) ? MARKER_MAX : 4;
  localparam int FILL_W  = $clog2(WIN_CAP + 1);

  typedef struct packed {
    logic [WIN_CAP-1:0][7:0] win;
    logic [FILL_W-1:0]       fill;
    logic [DEPTH_BITS-1:0]   depth;
    logic [1:0]              quote;
    logic [7:0]              prior;
    logic [1:0]              blank;
    logic                    rol;
    logic [1:0]              pair;
  } st_t;

  // Lengths above the window size act as the window size.
  function automatic logic [LEN_W-1:0] clip_len(logic [LEN_W-1:0] len);
    return (len > LEN_W'(WIN_CAP)) ? LEN_W'(WIN_CAP) : len;
  endfunction

  // A marker matches only when all of its bytes are in the window.
  function automatic logic win_match(st_t s, logic [31:0] pat, logic [LEN_W-1:0] len);
    logic ok;
    ok = (len <= LEN_W'(s.fill));
    for (int i = 0; i < WIN_CAP; i++) begin
      if ((LEN_W'(i) < len) && (s.win[i] != pat[8*i +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Decide the head byte, shift the window by one and record the output
  // byte in the prior field.
  function automatic st_t pop_head(st_t s, cbf_cfg_t c);
    st_t              n;
    logic [7:0]       h;
    logic [7:0]       v;
    logic [LEN_W-1:0] o;
    logic [LEN_W-1:0] cl;
    logic [LEN_W-1:0] l;
    n  = s;
    h  = s.win[0];
    o  = clip_len(c.open_len);
    cl = (c.close_len == '0) ? LEN_W'(1) : clip_len(c.close_len);
    l  = clip_len(c.line_len);
    if (s.pair != PAIR_NONE) begin
      v      = (s.pair == PAIR_BLANK) ? CH_SPACE : h;
      n.pair = PAIR_NONE;
    end else if (s.blank != 2'd0) begin
      n.blank = s.blank - 2'd1;
      v       = CH_SPACE;
    end else if (s.rol) begin
      v = body_blank(h);
    end else if ((s.depth != '0) && (s.quote == QUOTE_NONE)) begin
      // Inside a block comment.
      if (is_lead(h)) begin
        n.pair = PAIR_BLANK;
        v      = CH_SPACE;
      end else if ((o != '0) && win_match(s, c.open_marker, o)) begin
        n.blank = 2'(o - LEN_W'(1));
        if (!(&s.depth)) begin
          n.depth = s.depth + DEPTH_BITS'(1);
        end
        v = CH_SPACE;
      end else if ((o != '0) && win_match(s, c.close_marker, cl)) begin
        n.blank = 2'(cl - LEN_W'(1));
        n.depth = s.depth - DEPTH_BITS'(1);
        v       = CH_SPACE;
      end else begin
        v = body_blank(h);
      end
    end else if (is_lead(h)) begin
      n.pair = PAIR_PASS;
      v      = h;
    end else if ((s.quote == QUOTE_NONE) && (o != '0) && win_match(s, c.open_marker, o)) begin
      n.blank = 2'(o - LEN_W'(1));
      if (!(&s.depth)) begin
        n.depth = s.depth + DEPTH_BITS'(1);
      end
      v = CH_SPACE;
    end else if ((s.quote == QUOTE_NONE) && (l != '0) && win_match(s, c.line_marker, l)) begin
      n.rol = 1'b1;
      v     = body_blank(h);
    end else begin
      // Plain text: with quote tracking on, track string boundaries unless escaped.
      v = h;
      if (c.track_quotes && (s.prior != CH_BACKSLASH)) begin
        if (h == CH_SQUOTE) begin
          if (s.quote == QUOTE_NONE) begin
            n.quote = QUOTE_SINGLE;
          end else if (s.quote == QUOTE_SINGLE) begin
            n.quote = QUOTE_NONE;
          end
        end else if (h == CH_DQUOTE) begin
          if (s.quote == QUOTE_NONE) begin
            n.quote = QUOTE_DOUBLE;
          end else if (s.quote == QUOTE_DOUBLE) begin
            n.quote = QUOTE_NONE;
          end
        end
      end
    end
    for (int i = 0; i < WIN_CAP - 1; i++) begin
      n.win[i] = s.win[i+1];
    end
    n.fill  = s.fill - FILL_W'(1);
    n.prior = v;
    return n;
  endfunction

  // Configuration, input register, state and result signals.
  cbf_cfg_t                  cfg_r;
  logic                      in_v_r;
  logic [7:0]                in_byte_r;
  logic                      in_le_r;
  logic [WIN_CAP-1:0][7:0]   win_r;
  logic [FILL_W-1:0]         fill_r;
  logic [DEPTH_BITS-1:0]     depth_r;
  logic [1:0]                quote_r;
  logic [7:0]                prior_r;
  logic [1:0]                blank_r;
  logic                      rol_r;
  logic [1:0]                pair_r;
  st_t                       st_nxt;
  logic [LEN_W-1:0]          need_len;
  logic [FILL_W-1:0]         res_cnt;
  cbf_result_t [WIN_CAP-1:0] res_data;
  logic [FILL_W-1:0]         q_wr_cnt;
  logic                      q_space_ok;
  logic                      step_fire;
  cbf_result_t               q_data;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_marker  <= '0;
      cfg_r.line_len     <= '0;
      cfg_r.open_marker  <= '0;
      cfg_r.open_len     <= '0;
      cfg_r.close_marker <= '0;
      cfg_r.close_len    <= LEN_W'(1);
      cfg_r.track_quotes <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_MARKER:      cfg_r.line_marker  <= cfg_data;
        REG_LINE_MARKER_LEN:  cfg_r.line_len     <= cfg_data[LEN_W-1:0];
        REG_OPEN_MARKER:      cfg_r.open_marker  <= cfg_data;
        REG_OPEN_MARKER_LEN:  cfg_r.open_len     <= cfg_data[LEN_W-1:0];
        REG_CLOSE_MARKER:     cfg_r.close_marker <= cfg_data;
        REG_CLOSE_MARKER_LEN: cfg_r.close_len    <= cfg_data[LEN_W-1:0];
        REG_TRACK_QUOTES:     cfg_r.track_quotes <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: holds one beat until the queue can take its results.
  assign step_fire = in_v_r && q_space_ok;
  assign in_ready  = !in_v_r || q_space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
      in_le_r   <= in_line_end;
    end
  end

  // Window bytes needed before the head byte can be decided.
  always_comb begin
    logic [LEN_W-1:0] l;
    logic [LEN_W-1:0] o;
    logic [LEN_W-1:0] c;
    l = clip_len(cfg_r.line_len);
    o = clip_len(cfg_r.open_len);
    c = (cfg_r.close_len == '0) ? LEN_W'(1) : clip_len(cfg_r.close_len);
    need_len = LEN_W'(1);
    if (l > need_len) begin
      need_len = l;
    end
    if (cfg_r.open_len != '0) begin
      if (o > need_len) begin
        need_len = o;
      end
      if (c > need_len) begin
        need_len = c;
      end
    end
  end

  // One byte step: push into the window, then decide as many head bytes
  // as are ready, at most a window's worth.
  always_comb begin
    st_t  cur;
    logic act;
    logic go;
    cur.win   = win_r;
    cur.fill  = fill_r;
    cur.depth = depth_r;
    cur.quote = quote_r;
    cur.prior = prior_r;
    cur.blank = blank_r;
    cur.rol   = rol_r;
    cur.pair  = pair_r;
    res_cnt   = '0;
    res_data  = '0;
    act       = 1'b1;
    if (cur.fill < FILL_W'(WIN_CAP)) begin
      for (int i = 0; i < WIN_CAP; i++) begin
        if (cur.fill == FILL_W'(i)) begin
          cur.win[i] = in_byte_r;
        end
      end
      cur.fill = cur.fill + FILL_W'(1);
    end
    for (int k = 0; k < WIN_CAP; k++) begin
      go = in_le_r || (LEN_W'(cur.fill) >= need_len) || (cur.pair != PAIR_NONE) ||
           (cur.blank != 2'd0) || cur.rol;
      if (act && (cur.fill != '0) && go) begin
        cur                  = pop_head(cur, cfg_r);
        res_data[k].data     = cur.prior;
        res_data[k].line_end = in_le_r && (cur.fill == '0);
        res_cnt              = res_cnt + FILL_W'(1);
      end else begin
        act = 1'b0;
      end
    end
    // Line end clears the per-line state.
    if (in_le_r) begin
      cur.fill  = '0;
      cur.prior = '0;
      cur.blank = 2'd0;
      cur.rol   = 1'b0;
      cur.pair  = PAIR_NONE;
    end
    st_nxt = cur;
  end

  // Filter state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      depth_r <= '0;
      quote_r <= QUOTE_NONE;
      prior_r <= '0;
      blank_r <= 2'd0;
      rol_r   <= 1'b0;
      pair_r  <= PAIR_NONE;
    end else if (step_fire) begin
      fill_r  <= st_nxt.fill;
      depth_r <= st_nxt.depth;
      quote_r <= st_nxt.quote;
      prior_r <= st_nxt.prior;
      blank_r <= st_nxt.blank;
      rol_r   <= st_nxt.rol;
      pair_r  <= st_nxt.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      win_r <= st_nxt.win;
    end
  end

  // Result queue.
  assign q_wr_cnt = step_fire ? res_cnt : '0;

  cbf_out_queue #(
    .WR_MAX    (WIN_CAP),
    .ADDR_BITS (Q_ADDR_BITS)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_cnt    (q_wr_cnt),
    .wr_data   (res_data),
    .space_ok  (q_space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  assign out_byte     = q_data.data;
  assign out_line_end = q_data.line_end;

  // A line end beat leaves no per-line state behind.
  a_line_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && in_le_r) |=> ((fill_r == '0) && !rol_r && (pair_r == PAIR_NONE) &&
                                (blank_r == 2'd0) && (prior_r == '0)))
    else $error("per-line state not cleared at line end");

  // After a mid-line beat the window is short of a full marker.
  a_window_short: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && !in_le_r) |=> (LEN_W'(fill_r) < $past(need_len)))
    else $error("window left holding a decidable byte");

  // A line end beat always flushes at least its own byte.
  a_line_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && in_le_r) |-> (res_cnt != '0))
    else $error("line end beat produced no result");

endmodule
`default_nettype wire
